### hw/rtl/nmdamb_pkg.sv
// nmdamb_pkg: constants, register indexes and helper functions of the magnesium block
package nmdamb_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int VOLT_W   = 20;
   localparam int COND_W   = 32;
   localparam int SCALE_W  = 32;
   localparam int VSCALE_W = 25;
   localparam int CUR_W    = 53;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 88;

   localparam int LOG2E_W = 31;
   localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;

   // |vm| * log2(e) in Q30, and one quotient bit per divider stage
   localparam int PROD_W = VOLT_W - 1 + LOG2E_W;
   localparam int EXP_W  = 22;
   localparam int FRAC_IN_W = 16;
   localparam int MANT_W = 31;
   localparam int P_W    = SCALE_W + MANT_W;
   localparam int DEN_W  = 63;
   localparam int D_W    = 24;

   localparam logic [SCALE_W-1:0]  BLOCK_SCALE_RST = 32'd65536;
   localparam logic [VSCALE_W-1:0] VOLTAGE_SCALE_RST = 25'd1048576;
   localparam logic [SCALE_W-1:0]  MG_CONC_RST = 32'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SCALE   = 2'd0,
      CSR_VOLTAGE_SCALE = 2'd1,
      CSR_MG_CONC       = 2'd2
   } csr_index_type;

   // 2^(2^-(j+1)) in Q30
   function automatic logic [MANT_W-1:0] pow_tab(input logic [3:0] j);
      logic [MANT_W-1:0] t;
      case (j)
         4'd0:  t = 31'd1518500250;
         4'd1:  t = 31'd1276901417;
         4'd2:  t = 31'd1170923762;
         4'd3:  t = 31'd1121280436;
         4'd4:  t = 31'd1097253708;
         4'd5:  t = 31'd1085434106;
         4'd6:  t = 31'd1079572136;
         4'd7:  t = 31'd1076653033;
         4'd8:  t = 31'd1075196443;
         4'd9:  t = 31'd1074468888;
         4'd10: t = 31'd1074105294;
         4'd11: t = 31'd1073923544;
         4'd12: t = 31'd1073832680;
         4'd13: t = 31'd1073787251;
         4'd14: t = 31'd1073764537;
         4'd15: t = 31'd1073753181;
         default: t = 31'd1073741824;
      endcase
      return t;
   endfunction

   // position of the highest set bit, zero for zero
   function automatic logic [4:0] msb_pos(input logic [SCALE_W-1:0] x);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < SCALE_W; i++) begin
         if (x[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

endpackage

### hw/rtl/nmda_magnesium_block_core.sv
// nmda_magnesium_block_core: pipelined magnesium block of the nmda conductance
// throughput: one request per cycle; the whole pipeline holds while the result is not taken
// depth is set by the 50-stage voltage/B divider, 16 exponent multiply stages and the
// FRACTION_BITS-stage fraction divider
// reset: synchronous, clears the valid bits and sets A, B and C to 1.0, 1 V and 1.0 mM
module nmda_magnesium_block_core #(
   parameter int FRACTION_BITS = nmdamb_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // membrane_voltage, open_conductance, reversal_voltage
   input  logic [nmdamb_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // blocked_conductance, channel_current, zero fill
   output logic [nmdamb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [nmdamb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nmdamb_pkg::SCALE_W-1:0]        csr_wdata
);
   import nmdamb_pkg::*;

   localparam int FB = FRACTION_BITS;

   typedef struct packed {
      logic [COND_W-1:0]        g;
      logic signed [VOLT_W:0]   dv;
   } side_type;

   typedef struct packed {
      logic                 v;
      logic                 neg;
      logic [VSCALE_W-1:0]  rem;
      logic [PROD_W-1:0]    word;
      side_type             sd;
   } div1_type;

   typedef struct packed {
      logic                     v;
      logic [MANT_W-1:0]        m;
      logic [FRAC_IN_W-1:0]     fb;
      logic signed [EXP_W-1:0]  n;
      side_type                 sd;
   } pow_type;

   typedef struct packed {
      logic              v;
      logic              sat_zero;
      logic              sat_full;
      logic [DEN_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [FB-1:0]     q;
      side_type          sd;
   } div2_type;

   // configuration registers and derived normalization
   logic [SCALE_W-1:0]  block_scale_ff, mg_conc_ff;
   logic [VSCALE_W-1:0] voltage_scale_ff;
   logic [4:0]          pa_ff, pc_ff;
   logic [31:0]         qm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_scale_ff   <= BLOCK_SCALE_RST;
         voltage_scale_ff <= VOLTAGE_SCALE_RST;
         mg_conc_ff       <= MG_CONC_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BLOCK_SCALE: begin
               if (csr_wdata != '0) block_scale_ff <= csr_wdata;
            end
            CSR_VOLTAGE_SCALE: begin
               if (csr_wdata[VSCALE_W-1:0] != '0) voltage_scale_ff <= csr_wdata[VSCALE_W-1:0];
            end
            CSR_MG_CONC: begin
               if (csr_wdata != '0) mg_conc_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= msb_pos(block_scale_ff);
      pc_ff <= msb_pos(mg_conc_ff);
      qm_ff <= 32'(mg_conc_ff << (5'd31 - msb_pos(mg_conc_ff)));
   end

   logic adv;
   logic s8_v_ff;
   assign adv = !s8_v_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: unpack
   logic                    s1_v_ff, s1_neg_ff;
   logic [VOLT_W-1:0]       s1_abs_ff;
   side_type                s1_sd_ff;
   logic signed [VOLT_W-1:0] in_vm, in_ev;
   logic [VOLT_W-1:0]       in_abs;

   always_comb begin
      in_vm  = $signed(req_tdata[VOLT_W-1:0]);
      in_ev  = $signed(req_tdata[REQ_DATA_W-1:VOLT_W+COND_W]);
      in_abs = in_vm[VOLT_W-1] ? VOLT_W'(-in_vm) : VOLT_W'(in_vm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff   <= in_vm[VOLT_W-1];
         s1_abs_ff   <= in_abs;
         s1_sd_ff.g  <= req_tdata[VOLT_W+COND_W-1:VOLT_W];
         s1_sd_ff.dv <= (VOLT_W+1)'(in_ev) - (VOLT_W+1)'(in_vm);
      end
   end

   // stage 2: |vm| * log2(e)
   div1_type s2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.v <= 1'b0;
      end else if (adv) begin
         s2_ff.v    <= s1_v_ff;
         s2_ff.neg  <= s1_neg_ff;
         s2_ff.rem  <= '0;
         s2_ff.word <= PROD_W'(s1_abs_ff * LOG2E_Q30);
         s2_ff.sd   <= s1_sd_ff;
      end
   end

   // restoring divider by B, one quotient bit per stage, quotient shifts into word
   div1_type d1_ff [PROD_W];
   genvar k;
   generate
      for (k = 0; k < PROD_W; k++) begin : g_div1
         div1_type src, d1_in;
         logic [VSCALE_W:0] r;
         if (k == 0) begin : g_first
            assign src = s2_ff;
         end else begin : g_next
            assign src = d1_ff[k-1];
         end
         always_comb begin
            d1_in = src;
            r = {src.rem, src.word[PROD_W-1]};
            if (r >= {1'b0, voltage_scale_ff}) begin
               d1_in.rem  = VSCALE_W'(r - {1'b0, voltage_scale_ff});
               d1_in.word = {src.word[PROD_W-2:0], 1'b1};
            end else begin
               d1_in.rem  = r[VSCALE_W-1:0];
               d1_in.word = {src.word[PROD_W-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               d1_ff[k].v <= 1'b0;
            end else if (adv) begin
               d1_ff[k] <= d1_in;
            end
         end
      end
   endgenerate

   // stage 3: split into integer and fractional exponent (floor toward minus infinity)
   pow_type s3_in, s3_ff;
   logic [PROD_W-31:0] mag_hi;
   logic [29:0]        mag_lo, f;
   always_comb begin
      mag_hi = d1_ff[PROD_W-1].word[PROD_W-1:30];
      mag_lo = d1_ff[PROD_W-1].word[29:0];
      s3_in.v  = d1_ff[PROD_W-1].v;
      s3_in.m  = 31'h4000_0000;
      s3_in.sd = d1_ff[PROD_W-1].sd;
      if (!d1_ff[PROD_W-1].neg) begin
         s3_in.n = EXP_W'(mag_hi);
         f = mag_lo;
      end else if (mag_lo != '0) begin
         s3_in.n = ~EXP_W'(mag_hi);
         f = 30'(-mag_lo);
      end else begin
         s3_in.n = -EXP_W'(mag_hi);
         f = '0;
      end
      s3_in.fb = f[29:14];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.v <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   // 2^f as a product of table entries, one multiply per stage
   pow_type pw_ff [FRAC_IN_W];
   generate
      for (k = 0; k < FRAC_IN_W; k++) begin : g_pow
         pow_type src, pw_in;
         logic [2*MANT_W-1:0] prod;
         if (k == 0) begin : g_first
            assign src = s3_ff;
         end else begin : g_next
            assign src = pw_ff[k-1];
         end
         always_comb begin
            pw_in = src;
            prod  = src.m * pow_tab(4'(k));
            if (src.fb[FRAC_IN_W-1-k]) begin
               pw_in.m = prod[MANT_W+29:30];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               pw_ff[k].v <= 1'b0;
            end else if (adv) begin
               pw_ff[k] <= pw_in;
            end
         end
      end
   endgenerate

   // stage 4: P = A * m, partial exponent difference
   logic                 s4_v_ff;
   logic [P_W-1:0]       s4_p_ff;
   logic signed [D_W-1:0] s4_dd_ff;
   side_type             s4_sd_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= pw_ff[FRAC_IN_W-1].v;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_p_ff  <= block_scale_ff * pw_ff[FRAC_IN_W-1].m;
         s4_dd_ff <= D_W'(pc_ff) - D_W'(pa_ff) - D_W'(pw_ff[FRAC_IN_W-1].n);
         s4_sd_ff <= pw_ff[FRAC_IN_W-1].sd;
      end
   end

   // stage 5: normalize P to a 32-bit mantissa; its top bit is at pa+30 or pa+31
   logic                  s5_v_ff;
   logic [31:0]           s5_pm_ff, pm_in;
   logic signed [D_W-1:0] s5_d_ff;
   side_type              s5_sd_ff;
   logic                  c_top;
   logic [4:0]            shamt;
   always_comb begin
      c_top = s4_p_ff[6'(pa_ff) + 6'd31];
      shamt = 5'(pa_ff - 5'd1 + 5'(c_top));
      if (pa_ff == '0 && !c_top) begin
         pm_in = {s4_p_ff[30:0], 1'b0};
      end else begin
         pm_in = 32'(s4_p_ff >> shamt);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_pm_ff <= pm_in;
         s5_d_ff  <= s4_dd_ff - D_W'(c_top);
         s5_sd_ff <= s4_sd_ff;
      end
   end

   // stage 6: saturation and denominator pm + qm * 2^d
   div2_type s6_in, s6_ff;
   logic [DEN_W-1:0] qs;
   logic [4:0]       nd;
   always_comb begin
      nd = 5'(-s5_d_ff);
      if (s5_d_ff >= 0) begin
         qs = {31'b0, qm_ff} << s5_d_ff[4:0];
      end else begin
         qs = {31'b0, qm_ff >> nd};
      end
      s6_in.v        = s5_v_ff;
      s6_in.sat_zero = s5_d_ff >= D_W'(31);
      s6_in.sat_full = s5_d_ff <= -D_W'(32);
      s6_in.rem      = {31'b0, s5_pm_ff};
      s6_in.den      = {31'b0, s5_pm_ff} + qs;
      s6_in.q        = '0;
      s6_in.sd       = s5_sd_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ff.v <= 1'b0;
      end else if (adv) begin
         s6_ff <= s6_in;
      end
   end

   // fraction divider pm * 2^FB / den, pm < den so each stage yields one bit
   div2_type d2_ff [FB];
   generate
      for (k = 0; k < FB; k++) begin : g_div2
         div2_type src, d2_in;
         logic [DEN_W:0] r;
         if (k == 0) begin : g_first
            assign src = s6_ff;
         end else begin : g_next
            assign src = d2_ff[k-1];
         end
         always_comb begin
            d2_in = src;
            r = {src.rem, 1'b0};
            if (r >= {1'b0, src.den}) begin
               d2_in.rem = DEN_W'(r - {1'b0, src.den});
               d2_in.q   = {src.q[FB-2:0], 1'b1};
            end else begin
               d2_in.rem = r[DEN_W-1:0];
               d2_in.q   = {src.q[FB-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               d2_ff[k].v <= 1'b0;
            end else if (adv) begin
               d2_ff[k] <= d2_in;
            end
         end
      end
   endgenerate

   // stage 7: blocked conductance
   logic                     s7_v_ff;
   logic [COND_W-1:0]        s7_blk_ff;
   logic signed [VOLT_W:0]   s7_dv_ff;
   logic [FB:0]              frac;
   logic [COND_W+FB:0]       gprod;
   always_comb begin
      if (d2_ff[FB-1].sat_full) begin
         frac = (FB+1)'(1) << FB;
      end else if (d2_ff[FB-1].sat_zero) begin
         frac = '0;
      end else begin
         frac = {1'b0, d2_ff[FB-1].q};
      end
      gprod = d2_ff[FB-1].sd.g * frac;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= d2_ff[FB-1].v;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_blk_ff <= gprod[COND_W+FB-1:FB];
         s7_dv_ff  <= d2_ff[FB-1].sd.dv;
      end
   end

   // stage 8: current, result register
   logic [COND_W-1:0]       s8_blk_ff;
   logic signed [CUR_W-1:0] s8_cur_ff;
   logic signed [COND_W+VOLT_W+1:0] cprod;
   assign cprod = $signed({1'b0, s7_blk_ff}) * s7_dv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else if (adv) begin
         s8_v_ff <= s7_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s8_blk_ff <= s7_blk_ff;
         s8_cur_ff <= cprod[CUR_W-1:0];
      end
   end

   assign rsp_tvalid = s8_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W-COND_W-CUR_W)'(0), s8_cur_ff, s8_blk_ff};

`ifndef NO_ASSERTIONS
   // refused zero writes keep every scale register nonzero
   a_regs_nonzero: assert property (@(posedge clock) disable iff (reset)
      block_scale_ff != '0 && voltage_scale_ff != '0 && mg_conc_ff != '0)
      else $error("scale register holds zero");

   // 2^f stays within [1, 2) in Q30
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      pw_ff[FRAC_IN_W-1].v |-> pw_ff[FRAC_IN_W-1].m[30])
      else $error("exponent mantissa out of range");

   // normalized P mantissa has its top bit set
   a_pm_norm: assert property (@(posedge clock) disable iff (reset)
      s5_v_ff |-> s5_pm_ff[31])
      else $error("P mantissa not normalized");

   // unsaturated denominator exceeds the numerator, so the fraction stays below one
   a_den_gt_pm: assert property (@(posedge clock) disable iff (reset)
      (s6_ff.v && !s6_ff.sat_zero && !s6_ff.sat_full) |-> (s6_ff.den > s6_ff.rem))
      else $error("fraction denominator not above numerator");
`endif

endmodule

### dv/tb_nmda_magnesium_block_core.sv
// testbench of the nmda magnesium block core: predicted conductance and current vs the dut
`timescale 1ns / 100ps

class conductance_ledger;
   typedef struct packed {
      logic [31:0] blocked;
      logic [52:0] current;
   } blocked_result_type;

   blocked_result_type pending_q[$];
   int errors;
   logic [31:0] block_scale;
   logic [24:0] voltage_scale;
   logic [31:0] mg_conc;
   longint unsigned exp_steps[16];

   function new();
      exp_steps = '{64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
                    64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033,
                    64'd1075196443, 64'd1074468888, 64'd1074105294, 64'd1073923544,
                    64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181};
      errors = 0;
      block_scale = nmdamb_pkg::BLOCK_SCALE_RST;
      voltage_scale = nmdamb_pkg::VOLTAGE_SCALE_RST;
      mg_conc = nmdamb_pkg::MG_CONC_RST;
   endfunction

   // zero writes are refused, unknown indexes ignored
   function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
         nmdamb_pkg::CSR_BLOCK_SCALE:   if (val != 0) block_scale = val;
         nmdamb_pkg::CSR_VOLTAGE_SCALE: if (val[24:0] != 0) voltage_scale = val[24:0];
         nmdamb_pkg::CSR_MG_CONC:       if (val != 0) mg_conc = val;
         default: ;
      endcase
   endfunction

   // mantissa with bit 31 set, exponent out
   function logic [31:0] mantissa(longint unsigned x, output int e);
      e = 0;
      if (x == 0) return 32'd0;
      while (x >= 64'h1_0000_0000) begin
         x = x >> 1;
         e++;
      end
      while (x < 64'h8000_0000) begin
         x = x << 1;
         e--;
      end
      return x[31:0];
   endfunction

   function void note_request(logic signed [19:0] vm, logic [31:0] g, logic signed [19:0] ev);
      longint sv, cur;
      longint unsigned absv, mag, low, f, m, qs, den, frac, blk;
      int n, pe, qe, d;
      logic [31:0] pm, qm;
      blocked_result_type r;
      sv = vm;
      absv = sv < 0 ? -sv : sv;
      mag = absv * nmdamb_pkg::LOG2E_Q30 / voltage_scale;
      low = mag & 64'h3FFF_FFFF;
      if (sv >= 0) begin
         n = int'(mag >> 30);
         f = low;
      end else begin
         n = -int'(mag >> 30);
         if (low != 0) begin
            n = n - 1;
            f = (64'd1 << 30) - low;
         end else begin
            f = 0;
         end
      end
      m = 64'd1 << 30;
      for (int j = 0; j < 16; j++) begin
         if (f[29-j]) m = (m * exp_steps[j]) >> 30;
      end
      pm = mantissa(longint'(block_scale) * m, pe);
      qm = mantissa(longint'(mg_conc) << 30, qe);
      d = qe - n - pe;
      if (qm == 0) begin
         frac = 64'd1 << nmdamb_pkg::FRACTION_BITS_DEF;
      end else if (pm == 0 || d >= 31) begin
         frac = 0;
      end else if (d <= -32) begin
         frac = 64'd1 << nmdamb_pkg::FRACTION_BITS_DEF;
      end else begin
         qs = d >= 0 ? (longint'(qm) << d) : (longint'(qm) >> (-d));
         den = longint'(pm) + qs;
         frac = den != 0 ? ((longint'(pm) << nmdamb_pkg::FRACTION_BITS_DEF) / den) : 0;
      end
      blk = (longint'(g) * frac) >> nmdamb_pkg::FRACTION_BITS_DEF;
      cur = longint'(blk[31:0]) * (longint'(ev) - sv);
      r.blocked = blk[31:0];
      r.current = cur[52:0];
      pending_q.push_back(r);
   endfunction

   function void check_response(logic [87:0] data);
      blocked_result_type r;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected response %h", $time, data);
         errors++;
         return;
      end
      r = pending_q.pop_front();
      if (data[31:0] !== r.blocked) begin
         $display("%0t: blocked_conductance expected %h actual %h", $time, r.blocked,
                  data[31:0]);
         errors++;
      end
      if (data[84:32] !== r.current) begin
         $display("%0t: channel_current expected %h actual %h", $time, r.current,
                  data[84:32]);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_q.size();
   endfunction
endclass

module tb_nmda_magnesium_block_core;
   import nmdamb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SCALE_W-1:0] csr_wdata = '0;

   logic tx_idle = 1'b1;
   logic rx_idle = 1'b1;
   logic hold_go = 1'b0;
   int rx_stall = 0;
   int cycles = 0;
   conductance_ledger ledger = new();

   nmda_magnesium_block_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side, with random stalls and one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_response(rsp_tdata);
      if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else if (hold_go) begin
         rx_stall = 599;
         hold_go <= 1'b0;
         rsp_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
         rx_stall = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(logic [19:0] vm, logic [31:0] g, logic [19:0] ev);
      if (tx_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ev, g, vm};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(vm, g, ev);
   endtask

   task automatic send_random();
      logic [19:0] vm, ev;
      logic [31:0] g;
      vm = 20'($urandom());
      ev = 20'($urandom());
      g = $urandom();
      // bias some potentials toward the steep part of the curve
      if ($urandom_range(0, 3) == 0) vm = 20'($signed($urandom_range(0, 8191)) - 4096);
      case ($urandom_range(0, 9))
         0: g = 32'hFFFF_FFFF;
         1: g = 32'd0;
         default: ;
      endcase
      send_request(vm, g, ev);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      ledger.write_reg(idx, val);
   endtask

   task automatic wait_empty();
      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_scales(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      csr_write(CSR_BLOCK_SCALE, a);
      csr_write(CSR_VOLTAGE_SCALE, b);
      csr_write(CSR_MG_CONC, c);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the fields at the reset settings
      send_request(20'h80000, 32'hFFFF_FFFF, 20'h7FFFF);
      send_request(20'h7FFFF, 32'hFFFF_FFFF, 20'h80000);
      send_request(20'h00000, 32'hFFFF_FFFF, 20'h00000);
      send_request(20'h00001, 32'h0000_0001, 20'hFFFFF);
      send_request(20'hFFFFF, 32'h0000_0000, 20'h00001);
      send_request(20'h80000, 32'h0000_0000, 20'h80000);
      send_request(20'h7FFFF, 32'h8000_0000, 20'h7FFFF);
      send_request(20'h40000, 32'h1234_5678, 20'hC0000);
      wait_empty();

      // very positive and very negative exponents saturate
      set_scales(32'h0001_0000, 32'd1, 32'h0001_0000);
      send_request(20'h7FFFF, 32'hFFFF_FFFF, 20'h80000);
      send_request(20'h80000, 32'hFFFF_FFFF, 20'h7FFFF);
      send_request(20'h00001, 32'hFFFF_FFFF, 20'h00000);
      send_request(20'hFFFFF, 32'hFFFF_FFFF, 20'h00000);
      wait_empty();

      // refused zero writes, masked high bits, unknown register
      set_scales(32'd0, 32'd0, 32'd0);
      csr_write(CSR_NO_REG, 32'hDEAD_BEEF);
      csr_write(CSR_VOLTAGE_SCALE, 32'hFE00_0000);
      csr_write(CSR_VOLTAGE_SCALE, 32'hFE10_0000);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      send_request(20'h10000, 32'hFFFF_FFFF, 20'h00000);
      send_request(20'hF0000, 32'hFFFF_FFFF, 20'h00000);
      wait_empty();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_scales(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
            1: set_scales(32'd1, 32'h0100_0000, 32'd1);
            2: set_scales(32'd1, 32'h0001_0000, 32'hFFFF_FFFF);
            3: set_scales(32'hFFFF_FFFF, 32'h0000_4000, 32'd1);
            default: set_scales($urandom_range(1, 32'hFFFF_FFFF),
                                $urandom_range(1 << 14, 1 << 24),
                                $urandom_range(1, 32'hFFFF_FFFF));
         endcase
         if (ph == 4) hold_go <= 1'b1;
         if (ph == 6) begin
            tx_idle <= 1'b0;
            rx_idle <= 1'b0;
         end
         repeat (200) send_random();
         wait_empty();
      end

      if (ledger.errors == 0 && ledger.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/nmdamb_pkg.sv
hw/rtl/nmda_magnesium_block_core.sv
dv/tb_nmda_magnesium_block_core.sv
